FILE: design/cbor_item_head_encoder_assert.svh
// Assertion macros for the CBOR item head encoder checker.
`ifndef CBOR_ITEM_HEAD_ENCODER_ASSERT_SVH
`define CBOR_ITEM_HEAD_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CBOR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cbor encoder check failed");

// Next-cycle implication, disabled during reset.
`define CBOR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cbor encoder check failed");

`endif

FILE: design/cbor_enc_pkg.sv
// Shared types and codes for the CBOR item head encoder.
package cbor_enc_pkg;

    localparam logic [2:0] OP_HEAD       = 3'd0;
    localparam logic [2:0] OP_SIGNED_INT = 3'd1;
    localparam logic [2:0] OP_FLOAT32    = 3'd2;
    localparam logic [2:0] OP_FLOAT64    = 3'd3;
    localparam logic [2:0] OP_PAYLOAD    = 3'd4;
    localparam logic [2:0] OP_NEW_BUFFER = 3'd5;

    localparam logic [2:0] MAJOR_UINT = 3'd0;
    localparam logic [2:0] MAJOR_NINT = 3'd1;

    localparam logic [4:0] AI_UINT8  = 5'd24;
    localparam logic [4:0] AI_UINT16 = 5'd25;
    localparam logic [4:0] AI_UINT32 = 5'd26;
    localparam logic [4:0] AI_UINT64 = 5'd27;

    localparam logic [7:0] IB_FLOAT32 = 8'hFA;
    localparam logic [7:0] IB_FLOAT64 = 8'hFB;

    localparam int          CAP_W         = 17;
    localparam logic [16:0] CAP_RESET     = 17'd4096;

    // One classified request, handed from the front to the serializer.
    typedef struct packed {
        logic        first_valid;  // initial or payload byte was written
        logic [7:0]  first_byte;
        logic [63:0] arg;          // argument or float bits, big-endian out
        logic [3:0]  arg_len;      // argument bytes written after the first
        logic        status;       // buffer full
    } t_desc;

endpackage

FILE: design/cbor_enc_front.sv
// Request classifier and buffer capacity accounting.
module cbor_enc_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [16:0]                 i_cfg_wdata,
    input  logic                        i_push,
    input  logic                        i_q_full,
    input  logic [2:0]                  i_operation,
    input  logic [2:0]                  i_major_type,
    input  logic [63:0]                 i_value,
    output logic                        o_q_push,
    output cbor_enc_pkg::t_desc         o_desc
);
    import cbor_enc_pkg::*;

    logic [CAP_W-1:0] r_cap, n_cap;
    logic [CAP_W-1:0] r_bw, n_bw;

    logic [CAP_W-1:0] space;
    logic             is_write;
    logic [7:0]       first_byte;
    logic [63:0]      arg;
    logic [3:0]       arg_len;
    logic [2:0]       hd_major;
    logic [63:0]      hd_arg;
    logic [4:0]       hd_ai;
    logic [3:0]       hd_len;
    logic [4:0]       need;
    logic             fit1;
    logic             fit2;

    // Shortest-form head for the major type and argument.
    always_comb begin
        hd_major = i_major_type;
        hd_arg   = i_value;
        if (i_operation == OP_SIGNED_INT) begin
            hd_major = i_value[63] ? MAJOR_NINT : MAJOR_UINT;
            hd_arg   = i_value[63] ? ~i_value : i_value;
        end
        if (hd_arg < 64'd24) begin
            hd_ai  = hd_arg[4:0];
            hd_len = 4'd0;
        end else if (hd_arg[63:8] == '0) begin
            hd_ai  = AI_UINT8;
            hd_len = 4'd1;
        end else if (hd_arg[63:16] == '0) begin
            hd_ai  = AI_UINT16;
            hd_len = 4'd2;
        end else if (hd_arg[63:32] == '0) begin
            hd_ai  = AI_UINT32;
            hd_len = 4'd4;
        end else begin
            hd_ai  = AI_UINT64;
            hd_len = 4'd8;
        end
    end

    always_comb begin
        is_write   = 1'b1;
        first_byte = {hd_major, hd_ai};
        arg        = hd_arg;
        arg_len    = hd_len;
        case (i_operation)
            OP_HEAD, OP_SIGNED_INT: begin
            end
            OP_FLOAT32: begin
                first_byte = IB_FLOAT32;
                arg        = {32'd0, i_value[31:0]};
                arg_len    = 4'd4;
            end
            OP_FLOAT64: begin
                first_byte = IB_FLOAT64;
                arg        = i_value;
                arg_len    = 4'd8;
            end
            OP_PAYLOAD: begin
                first_byte = i_value[7:0];
                arg_len    = 4'd0;
            end
            default: begin
                is_write = 1'b0;
                arg_len  = 4'd0;
            end
        endcase
    end

    assign space = (r_cap > r_bw) ? (r_cap - r_bw) : '0;
    assign need  = 5'd1 + {1'b0, arg_len};
    assign fit1  = (space != '0);
    assign fit2  = (space >= {{(CAP_W-5){1'b0}}, need});

    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        o_desc.first_byte  = first_byte;
        o_desc.arg         = arg;
        o_desc.first_valid = 1'b0;
        o_desc.arg_len     = 4'd0;
        o_desc.status      = 1'b0;
        n_bw               = r_bw;
        if (is_write) begin
            if (!fit1) begin
                o_desc.status = 1'b1;
            end else if (!fit2) begin
                // head fits, argument dropped
                o_desc.first_valid = 1'b1;
                o_desc.status      = 1'b1;
                n_bw               = r_bw + 17'd1;
            end else begin
                o_desc.first_valid = 1'b1;
                o_desc.arg_len     = arg_len;
                n_bw               = r_bw + {{(CAP_W-5){1'b0}}, need};
            end
        end else if (i_operation == OP_NEW_BUFFER) begin
            n_bw = '0;
        end
    end

    assign n_cap = i_cfg_we ? i_cfg_wdata : r_cap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
            r_bw  <= '0;
        end else begin
            r_cap <= n_cap;
            if (o_q_push) begin
                r_bw <= n_bw;
            end
        end
    end

endmodule

FILE: design/cbor_enc_queue.sv
// Short descriptor queue between the classifier and the serializer.
module cbor_enc_queue #(
    parameter int DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  cbor_enc_pkg::t_desc i_desc,
    input  logic                i_pop,
    output cbor_enc_pkg::t_desc o_desc,
    output logic                o_full,
    output logic                o_empty
);
    import cbor_enc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_desc            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wptr, n_wptr;
    logic [PTR_W-1:0] r_rptr, n_rptr;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_desc  = r_mem[r_rptr];

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (i_push) begin
            n_wptr = (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
        end
        if (i_pop) begin
            n_rptr = (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_desc;
        end
    end

endmodule

FILE: design/cbor_enc_back.sv
// Byte serializer with a registered result stage.
module cbor_enc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cbor_enc_pkg::t_desc i_desc,
    input  logic                i_q_empty,
    output logic                o_q_pop,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [7:0]          o_out_byte,
    output logic                o_byte_valid,
    output logic                o_last,
    output logic                o_status
);
    import cbor_enc_pkg::*;

    logic       r_out_valid, n_out_valid;
    logic [7:0] r_byte;
    logic       r_bv;
    logic       r_last;
    logic       r_status;
    logic [3:0] r_pos, n_pos;

    logic       emit;
    logic [7:0] cur_byte;
    logic       cur_bv;
    logic       cur_last;
    logic [2:0] sh;
    logic [63:0] arg_sh;

    assign emit = !i_q_empty && (!r_out_valid || i_pop);

    // Argument bytes go out most significant first.
    assign sh     = 3'(i_desc.arg_len - r_pos);
    assign arg_sh = i_desc.arg >> {sh, 3'b000};

    always_comb begin
        if (r_pos == 4'd0) begin
            cur_bv   = i_desc.first_valid;
            cur_byte = i_desc.first_valid ? i_desc.first_byte : 8'd0;
            cur_last = !i_desc.first_valid || (i_desc.arg_len == 4'd0);
        end else begin
            cur_bv   = 1'b1;
            cur_byte = arg_sh[7:0];
            cur_last = (r_pos == i_desc.arg_len);
        end
    end

    assign o_q_pop = emit && cur_last;

    always_comb begin
        n_out_valid = r_out_valid;
        n_pos       = r_pos;
        if (emit) begin
            n_out_valid = 1'b1;
            n_pos       = cur_last ? 4'd0 : r_pos + 4'd1;
        end else if (i_pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pos       <= 4'd0;
        end else begin
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_byte   <= cur_byte;
            r_bv     <= cur_bv;
            r_last   <= cur_last;
            r_status <= cur_last && i_desc.status;
        end
    end

    assign o_empty      = !r_out_valid;
    assign o_out_byte   = r_byte;
    assign o_byte_valid = r_bv;
    assign o_last       = r_last;
    assign o_status     = r_status;

endmodule

FILE: design/cbor_item_head_encoder.sv
// CBOR item head encoder: a request is classified and checked against the
// buffer capacity in the cycle it is pushed, then queued; the serializer
// sends one result per cycle while results are popped. A request yields
// max(1, k) results, k being the bytes it writes (up to 9 for a 64-bit
// head or a float64), and holds the serializer until all are sent, so
// single-byte requests such as payload bytes run at one per cycle. Pushes
// are taken every cycle while the descriptor queue (QUEUE_DEPTH entries)
// has room, also while a result waits to be popped. A pushed request
// passes through the descriptor queue and then the registered result
// stage before its first result shows on the result ports to be popped.
module cbor_item_head_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_operation,
    input  logic [2:0]  i_major_type,
    input  logic [63:0] i_value,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_last,
    output logic        o_status
);
    import cbor_enc_pkg::*;

    t_desc front_desc;
    t_desc head_desc;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    assign full = q_full;

    cbor_enc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_push       (push),
        .i_q_full     (q_full),
        .i_operation  (i_operation),
        .i_major_type (i_major_type),
        .i_value      (i_value),
        .o_q_push     (q_push),
        .o_desc       (front_desc)
    );

    cbor_enc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_desc  (front_desc),
        .i_pop   (q_pop),
        .o_desc  (head_desc),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    cbor_enc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc       (head_desc),
        .i_q_empty    (q_empty),
        .o_q_pop      (q_pop),
        .i_pop        (pop),
        .o_empty      (empty),
        .o_out_byte   (o_out_byte),
        .o_byte_valid (o_byte_valid),
        .o_last       (o_last),
        .o_status     (o_status)
    );

endmodule

FILE: design/cbor_enc_checker.sv
// Port-level checker for the CBOR item head encoder, bound to the top level.
`include "cbor_item_head_encoder_assert.svh"

module cbor_enc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_byte,
    input logic        o_byte_valid,
    input logic        o_last,
    input logic        o_status
);

    // A waiting result stays until popped, unchanged.
    `CBOR_ASSERT_NEXT(a_hold_valid, i_clk, i_rst_n, !empty && !pop, !empty)
    `CBOR_ASSERT_NEXT(a_hold_data, i_clk, i_rst_n, !empty && !pop, $stable(o_out_byte) && $stable(o_byte_valid) && $stable(o_last) && $stable(o_status))
    // Buffer-full status only closes a request.
    `CBOR_ASSERT_NOW(a_status_last, i_clk, i_rst_n, !empty && o_status, o_last)
    // A result without a byte is the sole result of its request.
    `CBOR_ASSERT_NOW(a_nobyte_last, i_clk, i_rst_n, !empty && !o_byte_valid, o_last && (o_out_byte == 8'd0))

endmodule

bind cbor_item_head_encoder cbor_enc_checker u_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .empty        (empty),
    .pop          (pop),
    .o_out_byte   (o_out_byte),
    .o_byte_valid (o_byte_valid),
    .o_last       (o_last),
    .o_status     (o_status)
);

FILE: tb/cbor_item_head_encoder_checker.sv
// Checker for the CBOR item head encoder: predicts the encoded bytes and compares transfers.
`timescale 1ns / 100ps

module cbor_item_head_encoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [2:0]  i_operation,
    input  logic [2:0]  i_major_type,
    input  logic [63:0] i_value,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic [7:0]  i_out_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    input  logic        i_status,
    output int          o_pending,
    output int          o_failures
);
    import cbor_enc_pkg::*;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       last;
        logic       status;
    } t_enc_result;

    logic [16:0] capacity;
    logic [16:0] bytes_held;
    logic [7:0]  request_bytes[$];     // bytes written by the request being encoded
    t_enc_result encoded_results[$];   // oldest first

    // Append n bytes of v, big-endian, if they fit in the remaining room.
    function automatic bit write_piece(logic [63:0] v, int n);
        logic [16:0] room;
        room = (capacity > bytes_held) ? capacity - bytes_held : 17'd0;
        if (n > room)
            return 1'b0;
        for (int i = n - 1; i >= 0; i--)
            request_bytes.push_back(v[8*i +: 8]);
        bytes_held = bytes_held + 17'(n);
        return 1'b1;
    endfunction

    // Initial byte plus the shortest argument form.
    function automatic bit write_head(logic [2:0] major, logic [63:0] arg);
        logic [4:0] ai;
        int         n;
        if (arg < 64'd24) begin
            ai = arg[4:0];
            n = 0;
        end else if (arg <= 64'hFF) begin
            ai = AI_UINT8;
            n = 1;
        end else if (arg <= 64'hFFFF) begin
            ai = AI_UINT16;
            n = 2;
        end else if (arg <= 64'hFFFF_FFFF) begin
            ai = AI_UINT32;
            n = 4;
        end else begin
            ai = AI_UINT64;
            n = 8;
        end
        if (!write_piece({56'd0, major, ai}, 1))
            return 1'b0;
        if (n > 0)
            return write_piece(arg, n);
        return 1'b1;
    endfunction

    function automatic void predict_encoding(logic [2:0] op, logic [2:0] major,
                                             logic [63:0] val);
        bit          ok;
        t_enc_result res;
        ok = 1'b1;
        request_bytes.delete();
        case (op)
            OP_HEAD: begin
                ok = write_head(major, val);
            end
            OP_SIGNED_INT: begin
                if (val[63])
                    ok = write_head(MAJOR_NINT, ~val);
                else
                    ok = write_head(MAJOR_UINT, val);
            end
            OP_FLOAT32: begin
                ok = write_piece({56'd0, IB_FLOAT32}, 1);
                if (ok)
                    ok = write_piece({32'd0, val[31:0]}, 4);
            end
            OP_FLOAT64: begin
                ok = write_piece({56'd0, IB_FLOAT64}, 1);
                if (ok)
                    ok = write_piece(val, 8);
            end
            OP_PAYLOAD: begin
                ok = write_piece({56'd0, val[7:0]}, 1);
            end
            OP_NEW_BUFFER: begin
                bytes_held = 17'd0;
            end
            default: ;  // unused codes leave the state alone
        endcase

        if (request_bytes.size() == 0) begin
            res = '{out_byte: 8'd0, byte_valid: 1'b0, last: 1'b1, status: !ok};
            encoded_results.push_back(res);
        end else begin
            foreach (request_bytes[k]) begin
                res.out_byte   = request_bytes[k];
                res.byte_valid = 1'b1;
                res.last       = (k == request_bytes.size() - 1);
                res.status     = res.last && !ok;
                encoded_results.push_back(res);
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_enc_result want;
        if (!i_rst_n) begin
            capacity   = CAP_RESET;
            bytes_held = 17'd0;
            o_failures = 0;
            encoded_results.delete();
        end else begin
            if (i_cfg_we)
                capacity = i_cfg_wdata;

            if (i_pop && !i_empty) begin
                if (encoded_results.size() == 0) begin
                    $error("unexpected result transfer: out_byte %0h", i_out_byte);
                    o_failures++;
                end else begin
                    want = encoded_results.pop_front();
                    if (i_out_byte !== want.out_byte) begin
                        $error("out_byte: expected %0h, actual %0h",
                               want.out_byte, i_out_byte);
                        o_failures++;
                    end
                    if (i_byte_valid !== want.byte_valid) begin
                        $error("byte_valid: expected %0b, actual %0b",
                               want.byte_valid, i_byte_valid);
                        o_failures++;
                    end
                    if (i_last !== want.last) begin
                        $error("last: expected %0b, actual %0b", want.last, i_last);
                        o_failures++;
                    end
                    if (i_status !== want.status) begin
                        $error("status: expected %0b, actual %0b", want.status, i_status);
                        o_failures++;
                    end
                end
            end

            if (i_push && !i_full)
                predict_encoding(i_operation, i_major_type, i_value);
        end
        o_pending <= encoded_results.size();
    end

endmodule

FILE: tb/cbor_item_head_encoder_tb.sv
// Testbench top for the CBOR item head encoder: stimulus, idling and the verdict.
`timescale 1ns / 100ps

module cbor_item_head_encoder_tb;
    import cbor_enc_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int SETTLE_CYCLES    = 12;
    localparam int HOLD_CYCLES      = 120;
    localparam int RANDOM_PER_PHASE = 48;

    localparam logic [2:0] OP_UNUSED_A = 3'd6;
    localparam logic [2:0] OP_UNUSED_B = 3'd7;

    localparam logic [2:0] MAJOR_BSTR   = 3'd2;
    localparam logic [2:0] MAJOR_TSTR   = 3'd3;
    localparam logic [2:0] MAJOR_ARRAY  = 3'd4;
    localparam logic [2:0] MAJOR_MAP    = 3'd5;
    localparam logic [2:0] MAJOR_TAG    = 3'd6;
    localparam logic [2:0] MAJOR_SIMPLE = 3'd7;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [16:0] cfg_wdata = '0;
    logic        push = 1'b0;
    logic        full;
    logic [2:0]  operation = '0;
    logic [2:0]  major_type = '0;
    logic [63:0] value = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last;
    logic        status;

    int pending;
    int failures;
    int cycle_count = 0;
    bit hold_results = 1'b0;
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    always #(CLK_PERIOD / 2) clk = ~clk;

    cbor_item_head_encoder dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .push         (push),
        .full         (full),
        .i_operation  (operation),
        .i_major_type (major_type),
        .i_value      (value),
        .empty        (empty),
        .pop          (pop),
        .o_out_byte   (out_byte),
        .o_byte_valid (byte_valid),
        .o_last       (last),
        .o_status     (status)
    );

    cbor_item_head_encoder_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_wdata  (cfg_wdata),
        .i_push       (push),
        .i_full       (full),
        .i_operation  (operation),
        .i_major_type (major_type),
        .i_value      (value),
        .i_empty      (empty),
        .i_pop        (pop),
        .i_out_byte   (out_byte),
        .i_byte_valid (byte_valid),
        .i_last       (last),
        .i_status     (status),
        .o_pending    (pending),
        .o_failures   (failures)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Offer one request and hold it until the transfer.
    task automatic send_request(logic [2:0] op, logic [2:0] major, logic [63:0] val);
        int gap;
        if ($urandom_range(0, 15) == 0)
            send_steady = !send_steady;
        gap = send_steady ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        operation  <= op;
        major_type <= major;
        value      <= val;
        push       <= 1'b1;
        do @(posedge clk); while (full);
    endtask

    task automatic wait_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_capacity(logic [16:0] cap);
        wait_until_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [63:0] draw_argument();
        case ($urandom_range(0, 4))
            0:       return 64'($urandom_range(0, 23));
            1:       return 64'($urandom_range(24, 255));
            2:       return 64'($urandom_range(256, 65535));
            3:       return {32'd0, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Result side: random stalls plus one long hold-off.
    initial begin
        int gap;
        do @(posedge clk); while (!rst_n);
        forever begin
            if (hold_results) begin
                hold_results = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0)
                take_steady = !take_steady;
            gap = take_steady ? 0 : $urandom_range(0, 5);
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial begin
        logic [16:0] phase_caps[5];
        int          pick;
        logic [2:0]  op;
        logic [63:0] val;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every argument width at its boundaries, under the reset capacity.
        send_request(OP_HEAD, MAJOR_UINT, 64'd0);
        send_request(OP_HEAD, MAJOR_SIMPLE, 64'd23);
        send_request(OP_HEAD, MAJOR_BSTR, 64'd24);
        send_request(OP_HEAD, MAJOR_TSTR, 64'd255);
        send_request(OP_HEAD, MAJOR_ARRAY, 64'd256);
        send_request(OP_HEAD, MAJOR_MAP, 64'd65535);
        send_request(OP_HEAD, MAJOR_TAG, 64'd65536);
        send_request(OP_HEAD, MAJOR_NINT, 64'hFFFF_FFFF);
        send_request(OP_HEAD, MAJOR_UINT, 64'h1_0000_0000);
        send_request(OP_HEAD, MAJOR_SIMPLE, '1);
        send_request(OP_SIGNED_INT, MAJOR_TAG, 64'd0);
        send_request(OP_SIGNED_INT, MAJOR_UINT, '1);
        send_request(OP_SIGNED_INT, MAJOR_UINT, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(OP_SIGNED_INT, MAJOR_UINT, 64'h8000_0000_0000_0000);
        send_request(OP_FLOAT32, MAJOR_UINT, 64'hDEAD_BEEF_3F80_0000);
        send_request(OP_FLOAT64, MAJOR_UINT, 64'h0123_4567_89AB_CDEF);
        send_request(OP_PAYLOAD, MAJOR_SIMPLE, 64'hFFFF_FFFF_FFFF_FF00);
        send_request(OP_PAYLOAD, MAJOR_UINT, 64'h0000_0000_0000_00A5);
        send_request(OP_UNUSED_A, MAJOR_UINT, '1);
        send_request(OP_UNUSED_B, MAJOR_SIMPLE, 64'd0);

        // Tiny buffer: exact fit, overflow, capacity shrunk below the count, partial float.
        write_capacity(17'd3);
        send_request(OP_NEW_BUFFER, MAJOR_UINT, 64'd0);
        send_request(OP_HEAD, MAJOR_ARRAY, 64'd300);
        send_request(OP_PAYLOAD, MAJOR_UINT, 64'h42);
        write_capacity(17'd2);
        send_request(OP_HEAD, MAJOR_UINT, 64'd5);
        send_request(OP_NEW_BUFFER, MAJOR_UINT, '1);
        send_request(OP_FLOAT32, MAJOR_UINT, 64'h4049_0FDB);
        write_capacity(17'd0);
        send_request(OP_PAYLOAD, MAJOR_UINT, 64'h7E);

        phase_caps[0] = 17'($urandom_range(24, 60));
        phase_caps[1] = CAP_RESET;
        phase_caps[2] = 17'd65536;
        phase_caps[3] = 17'd0;
        phase_caps[4] = 17'h1FFFF;

        foreach (phase_caps[p]) begin
            write_capacity(phase_caps[p]);
            for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
                // Stall the result side mid-phase so the block backs up into the input.
                if (p == 1 && k == 10)
                    hold_results = 1'b1;
                pick = $urandom_range(0, 99);
                val = {$urandom(), $urandom()};
                if (pick < 30) begin
                    op = OP_HEAD;
                    val = draw_argument();
                end else if (pick < 45) begin
                    op = OP_SIGNED_INT;
                    val = draw_argument();
                    if ($urandom_range(0, 1))
                        val = ~val;
                end else if (pick < 55) begin
                    op = OP_FLOAT32;
                end else if (pick < 65) begin
                    op = OP_FLOAT64;
                end else if (pick < 87) begin
                    op = OP_PAYLOAD;
                end else if (pick < 96) begin
                    op = OP_NEW_BUFFER;
                end else begin
                    op = $urandom_range(0, 1) ? OP_UNUSED_A : OP_UNUSED_B;
                end
                send_request(op, 3'($urandom_range(0, 7)), val);
            end
        end

        wait_until_drained();
        if (failures == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+design
design/cbor_enc_pkg.sv
design/cbor_enc_front.sv
design/cbor_enc_queue.sv
design/cbor_enc_back.sv
design/cbor_item_head_encoder.sv
design/cbor_enc_checker.sv
tb/cbor_item_head_encoder_checker.sv
tb/cbor_item_head_encoder_tb.sv
